// ----- sv/dhsk_pkg.sv -----
`timescale 1ns / 1ps
// Shared definitions for the double-hashing key table: defaults, field widths,
// status and request codes, and the control struct of the modulo unit. No dependencies.
package dhsk_pkg;

  localparam int unsigned DEF_TABLE_SIZE = 59;
  localparam int unsigned DEF_KEY_CHARS  = 19;

  // Character code that maps to hash value zero.
  localparam int unsigned CHAR_BASE = 65;

  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned PROBE_W  = 6;
  localparam int unsigned COLL_W   = 16;
  localparam int unsigned OCC_W    = 6;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned OUT_W    = 40;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STS_INSERTED  = 3'd0,
    STS_PRESENT   = 3'd1,
    STS_FOUND     = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_FULL      = 3'd4
  } status_e;

  // Load request for the shared modulo unit; alt selects modulus TABLE_SIZE-1.
  typedef struct packed {
    logic load;
    logic alt;
  } mod_ctrl_t;

  // Signed accumulator width that holds a slot value plus any character offset.
  function automatic int unsigned acc_width(input int unsigned n);
    int unsigned sw;
    sw = $clog2(n);
    return ((sw > 8) ? sw : 8) + 2;
  endfunction

endpackage

// ----- sv/dhsk_mod_unit.sv -----
`timescale 1ns / 1ps
// Shared iterative modulo unit: reduces a signed value into [0, M) by adding or
// subtracting M once per cycle. Depends on dhsk_pkg.
module dhsk_mod_unit import dhsk_pkg::*; #(
  parameter int unsigned TABLE_SIZE = DEF_TABLE_SIZE,
  localparam int unsigned SW = $clog2(TABLE_SIZE),
  localparam int unsigned AW = acc_width(TABLE_SIZE)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mod_ctrl_t            ctrl_i,
  input  logic signed [AW-1:0] value_i,
  output logic                 done_o,
  output logic [SW-1:0]        rem_o
);

  localparam logic signed [AW-1:0] ModMain = AW'(TABLE_SIZE);
  localparam logic signed [AW-1:0] ModAlt  = AW'(TABLE_SIZE - 1);

  logic signed [AW-1:0] acc_q;
  logic                 alt_q;
  logic signed [AW-1:0] mod_w;

  assign mod_w = alt_q ? ModAlt : ModMain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      alt_q <= 1'b0;
    end else if (ctrl_i.load) begin
      acc_q <= value_i;
      alt_q <= ctrl_i.alt;
    end else if (acc_q < 0) begin
      acc_q <= acc_q + mod_w;
    end else if (acc_q >= mod_w) begin
      acc_q <= acc_q - mod_w;
    end
  end

  assign done_o = (acc_q >= 0) && (acc_q < mod_w);
  assign rem_o  = acc_q[SW-1:0];

endmodule

// ----- sv/double_hash_string_key_table.sv -----
`timescale 1ns / 1ps
// Top level of the double-hashing key table: sequencer, slot and key memories,
// counters and output register. Depends on dhsk_pkg and dhsk_mod_unit.
//
// Keys arrive on the slave stream one character per request: tdata carries the
// character, tuser the request type (insert or lookup) and tlast marks the final
// character. Only the request type on the final character counts. Characters past
// KEY_CHARS are dropped. The final character starts a probe sequence of slots
// (h1 + j*h2) mod TABLE_SIZE, and one result leaves on the master stream.
//
// Each stored character passes through the shared modulo unit, which computes both
// running hashes one after the other by add-or-subtract steps. Each probed slot takes
// a slot read, a compare of the stored key one byte at a time when the lengths match,
// and a step to the next slot through the same modulo unit. An insert then copies the
// key into the key memory one byte at a time. Memory reads are registered. tready is
// high only between requests.
//
// After reset the block sweeps the slot memory, one slot per cycle, and keeps tready
// low meanwhile. The result sits in an output register; the next key is accepted while
// it waits, and a later result waits inside the block until the receiver takes the
// earlier one.
module double_hash_string_key_table import dhsk_pkg::*; #(
  parameter int unsigned TABLE_SIZE = DEF_TABLE_SIZE,
  parameter int unsigned KEY_CHARS  = DEF_KEY_CHARS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [CHAR_W-1:0] s_axis_tdata_i,  // [7:0] key_char
  input  logic              s_axis_tuser_i,  // [0] req_type
  input  logic              s_axis_tlast_i,  // last_char
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // [2:0] status, [8:3] slot_index, [14:9] probe_count, [30:15] collision_total,
  // [36:31] occupied_slots, [39:37] zero
  output logic [OUT_W-1:0]  m_axis_tdata_o
);

  localparam int unsigned SW  = $clog2(TABLE_SIZE);
  localparam int unsigned JW  = $clog2(TABLE_SIZE + 1);
  localparam int unsigned LW  = $clog2(KEY_CHARS + 1);
  localparam int unsigned IW  = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
  localparam int unsigned KD  = TABLE_SIZE * KEY_CHARS;
  localparam int unsigned KAW = $clog2(KD);
  localparam int unsigned AW  = acc_width(TABLE_SIZE);
  localparam int unsigned MW  = LW + 1;
  localparam int unsigned CSW = COLL_W + 1;
  localparam logic [COLL_W-1:0] CollMax = '1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_READY,
    ST_HASH1,
    ST_HASH2,
    ST_PR_RD,
    ST_PR_CHK,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_ADV,
    ST_IDX,
    ST_CP_RD,
    ST_CP_WR,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [SW-1:0]     clr_q;
  logic [LW-1:0]     len_q;
  logic [SW-1:0]     fh_q;
  logic [SW-1:0]     sh_q;
  logic [CHAR_W-1:0] c_q;
  logic              last_q;
  logic              req_q;
  logic [SW-1:0]     idx_q;
  logic [JW-1:0]     j_q;
  logic [LW-1:0]     b_q;
  logic [KAW-1:0]    addr_q;
  logic [JW-1:0]     occ_q;
  logic [COLL_W-1:0] coll_q;
  status_e           res_status_q;
  logic [SW-1:0]     res_slot_q;
  logic [JW-1:0]     res_probes_q;
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  // Memories: incoming key, stored keys, and per-slot valid bit plus key length.
  logic [CHAR_W-1:0] inc_mem [KEY_CHARS];
  logic [CHAR_W-1:0] key_mem [KD];
  logic [MW-1:0]     meta_mem [TABLE_SIZE];
  logic [CHAR_W-1:0] inc_rd_q;
  logic [CHAR_W-1:0] key_rd_q;
  logic [MW-1:0]     meta_rd_q;

  logic              in_acc;
  logic              take_char;
  logic              meta_valid_w;
  logic [LW-1:0]     meta_len_w;
  logic [JW-1:0]     j_inc;
  logic              last_probe;
  logic [LW-1:0]     b_inc;
  logic [CSW-1:0]    coll_sum;
  logic              meta_we;
  logic [SW-1:0]     meta_wa;
  logic [MW-1:0]     meta_wd;

  mod_ctrl_t            mu_ctrl;
  logic signed [AW-1:0] mu_value;
  logic                 mu_done;
  logic [SW-1:0]        mu_rem;

  assign s_axis_tready_o = (state_q == ST_READY);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign take_char       = len_q < LW'(KEY_CHARS);
  assign meta_valid_w    = meta_rd_q[MW-1];
  assign meta_len_w      = meta_rd_q[LW-1:0];
  assign j_inc           = j_q + 1'b1;
  assign last_probe      = (j_inc == JW'(TABLE_SIZE));
  assign b_inc           = b_q + 1'b1;
  assign coll_sum        = {1'b0, coll_q} + CSW'(j_q);

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  dhsk_mod_unit #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mu_ctrl),
    .value_i(mu_value),
    .done_o (mu_done),
    .rem_o  (mu_rem)
  );

  // The modulo unit serves the first hash, the step hash and the probe advance.
  always_comb begin
    mu_ctrl  = '0;
    mu_value = '0;
    case (state_q)
      ST_READY: begin
        if (in_acc && take_char) begin
          mu_ctrl.load = 1'b1;
          mu_value = $signed(AW'(fh_q)) + $signed(AW'(s_axis_tdata_i))
                     - $signed(AW'(CHAR_BASE));
        end
      end
      ST_HASH1: begin
        if (mu_done) begin
          mu_ctrl.load = 1'b1;
          mu_ctrl.alt  = 1'b1;
          mu_value = $signed(AW'(sh_q)) + $signed(AW'(c_q)) - $signed(AW'(CHAR_BASE));
        end
      end
      ST_ADV: begin
        if (!last_probe) begin
          mu_ctrl.load = 1'b1;
          mu_value = $signed(AW'(idx_q)) + $signed(AW'(sh_q));
        end
      end
      default: begin
      end
    endcase
  end

  // Slot memory writes: the sweep after reset, and the claim of an empty slot.
  always_comb begin
    meta_we = 1'b0;
    meta_wa = idx_q;
    meta_wd = {1'b1, len_q};
    if (state_q == ST_CLEAR) begin
      meta_we = 1'b1;
      meta_wa = clr_q;
      meta_wd = '0;
    end else if (state_q == ST_PR_CHK && !meta_valid_w && req_q == REQ_INSERT) begin
      meta_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    meta_rd_q <= meta_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && take_char) begin
      inc_mem[len_q[IW-1:0]] <= s_axis_tdata_i;
    end
    inc_rd_q <= inc_mem[b_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CP_WR) begin
      key_mem[addr_q] <= inc_rd_q;
    end
    key_rd_q <= key_mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      len_q        <= '0;
      fh_q         <= '0;
      sh_q         <= '0;
      c_q          <= '0;
      last_q       <= 1'b0;
      req_q        <= REQ_INSERT;
      idx_q        <= '0;
      j_q          <= '0;
      b_q          <= '0;
      addr_q       <= '0;
      occ_q        <= '0;
      coll_q       <= '0;
      res_status_q <= STS_INSERTED;
      res_slot_q   <= '0;
      res_probes_q <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      // In ST_DONE the output register is either refilled or held below.
      if (out_valid_q && m_axis_tready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SW'(TABLE_SIZE - 1)) begin
            state_q <= ST_READY;
          end
        end
        ST_READY: begin
          if (in_acc) begin
            c_q    <= s_axis_tdata_i;
            last_q <= s_axis_tlast_i;
            req_q  <= s_axis_tuser_i;
            if (take_char) begin
              len_q   <= len_q + 1'b1;
              state_q <= ST_HASH1;
            end else if (s_axis_tlast_i) begin
              // Overlong key: hashes are final, go straight to probing.
              idx_q   <= fh_q;
              j_q     <= '0;
              state_q <= ST_PR_RD;
            end
          end
        end
        ST_HASH1: begin
          if (mu_done) begin
            fh_q    <= mu_rem;
            state_q <= ST_HASH2;
          end
        end
        ST_HASH2: begin
          if (mu_done) begin
            sh_q <= mu_rem + 1'b1;
            if (last_q) begin
              idx_q   <= fh_q;
              j_q     <= '0;
              state_q <= ST_PR_RD;
            end else begin
              state_q <= ST_READY;
            end
          end
        end
        ST_PR_RD: begin
          state_q <= ST_PR_CHK;
        end
        ST_PR_CHK: begin
          addr_q <= KAW'(idx_q * KEY_CHARS);
          b_q    <= '0;
          if (!meta_valid_w) begin
            res_probes_q <= j_inc;
            if (req_q == REQ_LOOKUP) begin
              res_status_q <= STS_NOT_FOUND;
              res_slot_q   <= '0;
              state_q      <= ST_DONE;
            end else begin
              res_status_q <= STS_INSERTED;
              res_slot_q   <= idx_q;
              occ_q        <= occ_q + 1'b1;
              coll_q       <= coll_sum[COLL_W] ? CollMax : coll_sum[COLL_W-1:0];
              state_q      <= ST_CP_RD;
            end
          end else if (meta_len_w == len_q) begin
            state_q <= ST_CMP_RD;
          end else begin
            state_q <= ST_ADV;
          end
        end
        ST_CMP_RD: begin
          state_q <= ST_CMP_CHK;
        end
        ST_CMP_CHK: begin
          if (key_rd_q != inc_rd_q) begin
            state_q <= ST_ADV;
          end else if (b_inc == len_q) begin
            res_status_q <= (req_q == REQ_LOOKUP) ? STS_FOUND : STS_PRESENT;
            res_slot_q   <= idx_q;
            res_probes_q <= j_inc;
            state_q      <= ST_DONE;
          end else begin
            b_q     <= b_inc;
            addr_q  <= addr_q + 1'b1;
            state_q <= ST_CMP_RD;
          end
        end
        ST_ADV: begin
          if (last_probe) begin
            res_status_q <= (req_q == REQ_LOOKUP) ? STS_NOT_FOUND : STS_FULL;
            res_slot_q   <= '0;
            res_probes_q <= j_inc;
            state_q      <= ST_DONE;
          end else begin
            j_q     <= j_inc;
            state_q <= ST_IDX;
          end
        end
        ST_IDX: begin
          if (mu_done) begin
            idx_q   <= mu_rem;
            state_q <= ST_PR_RD;
          end
        end
        ST_CP_RD: begin
          state_q <= ST_CP_WR;
        end
        ST_CP_WR: begin
          if (b_inc == len_q) begin
            state_q <= ST_DONE;
          end else begin
            b_q     <= b_inc;
            addr_q  <= addr_q + 1'b1;
            state_q <= ST_CP_RD;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {3'b000, OCC_W'(occ_q), COLL_W'(coll_q), PROBE_W'(res_probes_q),
                            SLOT_W'(res_slot_q), res_status_q};
            len_q       <= '0;
            fh_q        <= '0;
            sh_q        <= '0;
            state_q     <= ST_READY;
          end
        end
        default: begin
          state_q <= ST_READY;
        end
      endcase
    end
  end

  // The occupancy count can never pass the number of slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni) occ_q <= JW'(TABLE_SIZE))
    else $error("occupancy count exceeds table size");

  // The collision total only grows or saturates.
  assert property (@(posedge clk_i) disable iff (!rst_ni) coll_q >= $past(coll_q))
    else $error("collision total decreased");

  // Claiming an empty slot raises the occupancy by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PR_CHK && !meta_valid_w && req_q == REQ_INSERT)
    |=> occ_q == $past(occ_q) + 1'b1)
    else $error("insert did not update occupancy");

  // A finished result waits while the previous one is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !m_axis_tready_i) |=> state_q == ST_DONE)
    else $error("result overwritten while output stalled");

  // Probing only ever addresses a slot inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PR_RD) |-> {1'b0, idx_q} < (SW + 1)'(TABLE_SIZE))
    else $error("probe index out of range");

endmodule

// ----- verif/double_hash_string_key_table_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for double_hash_string_key_table: streams keys one character per
// request, predicts each probe outcome and checks the result stream field by field.
// Depends on dhsk_pkg and the RTL of the table only.
module double_hash_string_key_table_tb;
  import dhsk_pkg::*;

  localparam int TSIZE        = DEF_TABLE_SIZE;
  localparam int KCHARS       = DEF_KEY_CHARS;
  localparam int ITEM_TARGET  = 1350;
  localparam int POOL_MAX     = 96;
  localparam int DRAIN_CYCLES = 3000;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int COLL_SAT     = 65535;

  typedef logic [CHAR_W-1:0] char_t;

  // One character request as queued for the driver. A set hold bit makes the
  // driver wait until every outstanding result has been returned.
  typedef struct {
    logic  req;
    char_t ch;
    logic  last;
    bit    hold;
  } key_char_t;

  // Layout of the result word, status in the lowest bits.
  typedef struct packed {
    logic [OCC_W-1:0]   occ;
    logic [COLL_W-1:0]  coll;
    logic [PROBE_W-1:0] probes;
    logic [SLOT_W-1:0]  slot;
    status_e            status;
  } probe_result_t;

  logic             clk_i;
  logic             rst_ni          = 1'b0;
  logic             s_valid         = 1'b0;
  logic             s_axis_tready_o;
  char_t            s_tdata         = '0;
  logic             s_tuser         = 1'b0;
  logic             s_tlast         = 1'b0;
  logic             m_axis_tvalid_o;
  logic             m_tready        = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;

  double_hash_string_key_table u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stimulus queue and scoreboard.
  key_char_t     stim_q[$];
  key_char_t     cur_item;
  probe_result_t pending_results[$];
  int            chars_taken    = 0;
  int            results_seen   = 0;
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  int            status_seen[5] = '{default: 0};

  // Shadow copy of the table contents and hashing state.
  bit    slot_used [TSIZE];
  char_t slot_bytes[TSIZE][KCHARS];
  int    slot_len  [TSIZE];
  char_t key_buf   [KCHARS];
  int    key_len    = 0;
  int    h1         = 0;
  int    h2         = 0;
  int    coll_count = 0;
  int    occ_count  = 0;

  // Key generation scratch and a pool of earlier keys for repeats.
  char_t gen_key [32];
  char_t pool_key[POOL_MAX][KCHARS];
  int    pool_len[POOL_MAX];
  int    pool_count = 0;

  function automatic int mod_pos(input int v, input int m);
    int r;
    r = v % m;
    if (r < 0) r += m;
    return r;
  endfunction

  // Takes one accepted character; on the final character runs the probe sequence
  // and queues the result the block has to return.
  function automatic void hash_and_probe(input key_char_t it);
    probe_result_t res;
    int            idx;
    int            j;
    bit            done;
    bit            same;
    if (key_len < KCHARS) begin
      key_buf[key_len] = it.ch;
      key_len++;
      h1 = mod_pos(h1 + int'(it.ch) - int'(CHAR_BASE), TSIZE);
      h2 = 1 + mod_pos(h2 + int'(it.ch) - int'(CHAR_BASE), TSIZE - 1);
    end
    if (!it.last) return;

    res.status = (it.req == REQ_LOOKUP) ? STS_NOT_FOUND : STS_FULL;
    res.slot   = '0;
    res.probes = '0;
    idx  = h1;
    done = 1'b0;
    for (j = 0; j < TSIZE && !done; j++) begin
      res.probes = PROBE_W'(j + 1);
      if (!slot_used[idx]) begin
        if (it.req == REQ_LOOKUP) begin
          res.status = STS_NOT_FOUND;
        end else begin
          res.status      = STS_INSERTED;
          res.slot        = SLOT_W'(idx);
          slot_used[idx]  = 1'b1;
          slot_len[idx]   = key_len;
          for (int i = 0; i < key_len; i++) slot_bytes[idx][i] = key_buf[i];
          occ_count++;
          coll_count = (coll_count + j > COLL_SAT) ? COLL_SAT : coll_count + j;
        end
        done = 1'b1;
      end else begin
        same = (slot_len[idx] == key_len);
        for (int i = 0; i < key_len && same; i++) same = (slot_bytes[idx][i] == key_buf[i]);
        if (same) begin
          res.status = (it.req == REQ_LOOKUP) ? STS_FOUND : STS_PRESENT;
          res.slot   = SLOT_W'(idx);
          done       = 1'b1;
        end else begin
          idx = (idx + h2) % TSIZE;
        end
      end
    end
    res.coll = COLL_W'(coll_count);
    res.occ  = OCC_W'(occ_count);
    pending_results.push_back(res);
    key_len = 0;
    h1      = 0;
    h2      = 0;
  endfunction

  // Queues the first n characters of gen_key as one key. Only the request type
  // on the final character matters, so earlier ones get random values.
  task automatic push_key(input logic req, input int n, input bit hold);
    key_char_t it;
    for (int i = 0; i < n; i++) begin
      it.req  = (i == n - 1) ? req : logic'($urandom_range(0, 1));
      it.ch   = gen_key[i];
      it.last = (i == n - 1);
      it.hold = hold && (i == 0);
      stim_q.push_back(it);
    end
  endtask

  // Keeps the stored (truncated) form of the key in gen_key in the pool for later repeats.
  task automatic remember_key(input int n);
    int k;
    k = (pool_count < POOL_MAX) ? pool_count : $urandom_range(0, POOL_MAX - 1);
    if (pool_count < POOL_MAX) pool_count++;
    pool_len[k] = (n < KCHARS) ? n : KCHARS;
    for (int i = 0; i < pool_len[k]; i++) pool_key[k][i] = gen_key[i];
  endtask

  initial begin : stimulus
    int   n;
    int   k;
    int   pick;
    logic req;

    // Directed part: a single 'A' hashes to slot 0 with step 1.
    gen_key[0] = CHAR_W'(CHAR_BASE);
    push_key(REQ_INSERT, 1, 1'b0);
    push_key(REQ_LOOKUP, 1, 1'b0);
    push_key(REQ_INSERT, 1, 1'b0);                // duplicate insert
    gen_key[0] = CHAR_W'(CHAR_BASE + TSIZE);      // same first hash as 'A'
    push_key(REQ_INSERT, 1, 1'b0);
    gen_key[0] = CHAR_W'(CHAR_BASE + 1);          // empty slot, lookup misses
    push_key(REQ_LOOKUP, 1, 1'b0);
    gen_key[0] = 8'h00;                           // code zero and the top code
    gen_key[1] = 8'hFF;
    push_key(REQ_INSERT, 2, 1'b0);
    push_key(REQ_LOOKUP, 2, 1'b0);
    remember_key(2);
    for (int i = 0; i < KCHARS + 1; i++) gen_key[i] = char_t'($urandom_range(0, 255));
    push_key(REQ_INSERT, KCHARS + 1, 1'b0);       // one character past the limit
    remember_key(KCHARS + 1);

    // Random part: repeats of known keys mixed with fresh ones. Fresh inserts
    // fill the table about halfway through, after which the full-table paths
    // get exercised. The first random key waits for the directed results.
    while (stim_q.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      req  = (pick < 15 || (pick >= 45 && pick < 85)) ? REQ_INSERT : REQ_LOOKUP;
      if (pick < 45) begin
        k = $urandom_range(0, pool_count - 1);
        n = pool_len[k];
        for (int i = 0; i < n; i++) gen_key[i] = pool_key[k][i];
        // A full-length key may carry a tail that the block must drop.
        if (n == KCHARS && $urandom_range(0, 1) == 1) begin
          for (int i = 0; i < 4; i++) gen_key[n + i] = char_t'($urandom_range(0, 255));
          n += $urandom_range(1, 4);
        end
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(KCHARS - 2, KCHARS + 5)
                                        : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) gen_key[i] = char_t'($urandom_range(0, 255));
        if (req == REQ_INSERT) remember_key(n);
      end
      push_key(req, n, (stim_q.size() < 40) || ($urandom_range(0, 49) == 0));
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (stim_q.size() == 0 && !s_valid && pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d characters and %0d results: %0d inserted, %0d duplicate, %0d found,",
             chars_taken, results_seen, status_seen[STS_INSERTED], status_seen[STS_PRESENT],
             status_seen[STS_FOUND]);
    $display("%0d not found, %0d rejected as full; %0d slots used, %0d collisions, %0d mismatches.",
             status_seen[STS_NOT_FOUND], status_seen[STS_FULL], occ_count, coll_count,
             mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("double_hash_string_key_table_tb: clean");
    end else begin
      $display("double_hash_string_key_table_tb: errors");
    end
    $finish;
  end

  // Driver: presents the next queued character once the current request is
  // taken. Idles at random except for a stretch of back-to-back characters.
  always @(posedge clk_i) begin
    key_char_t nxt;
    bit        free;
    bit        quiet;
    if (rst_ni) begin
      free  = !s_valid || s_axis_tready_o;
      quiet = (chars_taken >= 300 && chars_taken < 650);
      if (s_valid && s_axis_tready_o) begin
        hash_and_probe(cur_item);
        chars_taken++;
      end
      if (free) begin
        if (stim_q.size() > 0 && !(stim_q[0].hold && pending_results.size() > 0) &&
            (quiet || $urandom_range(0, 99) >= 10)) begin
          nxt      = stim_q.pop_front();
          cur_item <= nxt;
          s_valid  <= 1'b1;
          s_tdata  <= nxt.ch;
          s_tuser  <= nxt.req;
          s_tlast  <= nxt.last;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each returned result against the oldest prediction and
  // stalls the result stream at random outside one steady stretch.
  always @(posedge clk_i) begin
    probe_result_t got;
    probe_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_tready) begin
        got = m_axis_tdata_o[$bits(probe_result_t)-1:0];
        results_seen++;
        if (got.status <= STS_FULL) status_seen[got.status]++;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] result with nothing outstanding: status %0d slot %0d probes %0d",
                     $realtime, got.status, got.slot, got.probes);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.probes !== want.probes || got.coll !== want.coll || got.occ !== want.occ) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("[%0t] result %0d mismatch", $realtime, results_seen);
              $display("  expected status %0d slot %0d probes %0d coll %0d occ %0d",
                       want.status, want.slot, want.probes, want.coll, want.occ);
              $display("  got      status %0d slot %0d probes %0d coll %0d occ %0d",
                       got.status, got.slot, got.probes, got.coll, got.occ);
            end
          end
        end
      end
      m_tready <= (results_seen >= 60 && results_seen < 130) || ($urandom_range(0, 99) >= 10);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("double_hash_string_key_table_tb: errors");
      $finish;
    end
  end

endmodule
